[rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg: shared definitions for the motor soft-start sequencer
// Configuration register indexes, reset values, item kinds and the settings
// bundle.
// ----------------------------------------------------------------------------
package mss_pkg;

    // widths fixed by the register map
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SBITS_W     = 5;

    // parameter defaults
    localparam int unsigned DUTY_WIDTH_DEF  = 16;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_BITS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TICKS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_FLOOR  = 3'd6;

    // register reset values
    localparam logic [SBITS_W-1:0] RST_SPEED_BITS   = 5'd8;
    localparam logic [TICKS_W-1:0] RST_BRAKE_TICKS  = 16'd500;
    localparam logic [TICKS_W-1:0] RST_SETTLE_TICKS = 16'd50;
    localparam logic [TICKS_W-1:0] RST_HOLD_TICKS   = 16'd100;
    localparam logic [TICKS_W-1:0] RST_STEP_TICKS   = 16'd20;
    localparam logic [BYTE_W-1:0]  RST_RAMP_STEP    = 8'd10;
    localparam logic [BYTE_W-1:0]  RST_START_FLOOR  = 8'd10;

    // item kinds; the last code is not a command and is ignored
    typedef enum logic [2:0] {
        KIND_TICK, KIND_FWD, KIND_REV, KIND_STOP,
        KIND_SPEED, KIND_FWD_KEEP, KIND_REV_KEEP, KIND_UNUSED
    } t_kind;

    // settings handed from the register block to the sequencer
    typedef struct packed {
        logic [TICKS_W-1:0] brake_ticks;
        logic [TICKS_W-1:0] settle_ticks;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] step_ticks;
        logic [BYTE_W-1:0]  ramp_step;    // already forced to at least 1
        logic [BYTE_W-1:0]  start_floor;
    } t_cfg;

endpackage

[rtl/mss_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mss_cfg_regs: configuration registers of the soft-start sequencer
// Holds the seven settings and derives the speed limit and the ramp step.
// ----------------------------------------------------------------------------
module mss_cfg_regs #(
    parameter int unsigned DUTY_WIDTH = mss_pkg::DUTY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mss_pkg::t_cfg                    o_cfg,
    output logic [DUTY_WIDTH-1:0]            o_max_speed
);

    logic [mss_pkg::SBITS_W-1:0] r_speed_bits;
    logic [mss_pkg::TICKS_W-1:0] r_brake_ticks;
    logic [mss_pkg::TICKS_W-1:0] r_settle_ticks;
    logic [mss_pkg::TICKS_W-1:0] r_hold_ticks;
    logic [mss_pkg::TICKS_W-1:0] r_step_ticks;
    logic [mss_pkg::BYTE_W-1:0]  r_ramp_step;
    logic [mss_pkg::BYTE_W-1:0]  r_start_floor;
    logic [mss_pkg::SBITS_W-1:0] bits_eff;
    logic [DUTY_WIDTH:0]         pow2;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_bits   <= mss_pkg::RST_SPEED_BITS;
            r_brake_ticks  <= mss_pkg::RST_BRAKE_TICKS;
            r_settle_ticks <= mss_pkg::RST_SETTLE_TICKS;
            r_hold_ticks   <= mss_pkg::RST_HOLD_TICKS;
            r_step_ticks   <= mss_pkg::RST_STEP_TICKS;
            r_ramp_step    <= mss_pkg::RST_RAMP_STEP;
            r_start_floor  <= mss_pkg::RST_START_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mss_pkg::REG_SPEED_BITS:   r_speed_bits   <= i_cfg_data[mss_pkg::SBITS_W-1:0];
                mss_pkg::REG_BRAKE_TICKS:  r_brake_ticks  <= i_cfg_data;
                mss_pkg::REG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                mss_pkg::REG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data;
                mss_pkg::REG_STEP_TICKS:   r_step_ticks   <= i_cfg_data;
                mss_pkg::REG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[mss_pkg::BYTE_W-1:0];
                mss_pkg::REG_START_FLOOR:  r_start_floor  <= i_cfg_data[mss_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // speed limit: resolution clamped to 1..DUTY_WIDTH
    always_comb begin
        if (r_speed_bits == '0) begin
            bits_eff = mss_pkg::SBITS_W'(1);
        end else if (r_speed_bits > mss_pkg::SBITS_W'(DUTY_WIDTH)) begin
            bits_eff = mss_pkg::SBITS_W'(DUTY_WIDTH);
        end else begin
            bits_eff = r_speed_bits;
        end
        pow2        = (DUTY_WIDTH+1)'(1) << bits_eff;
        o_max_speed = DUTY_WIDTH'(pow2 - (DUTY_WIDTH+1)'(1));
    end

    // settings bundle; a zero ramp step acts as one
    always_comb begin
        o_cfg.brake_ticks  = r_brake_ticks;
        o_cfg.settle_ticks = r_settle_ticks;
        o_cfg.hold_ticks   = r_hold_ticks;
        o_cfg.step_ticks   = r_step_ticks;
        o_cfg.ramp_step    = (r_ramp_step == '0) ? mss_pkg::BYTE_W'(1) : r_ramp_step;
        o_cfg.start_floor  = r_start_floor;
    end

endmodule

[rtl/motor_soft_start_sequencer_core.sv]
// ----------------------------------------------------------------------------
// motor_soft_start_sequencer_core: brushed-motor soft start and reversal
// Brake, direction settle, start hold and stepped duty ramp, advanced by
// tick items; one result per item carries the duty and status.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | i_in_valid, o_in_stall, i_kind, i_speed   | to core
//  out      | o_out_valid, i_out_stall, o_duty,         | from core
//           | o_reverse_dir, o_busy_res, o_running,     |
//           | o_speed_now, o_rejected                   |
//  cfg      | i_cfg_we, i_cfg_index, i_cfg_data         | to core
//
// One item per cycle while the result is not stalled. An item is captured in
// the input register; when it advances it updates the sequencer state and
// loads the result register, from which its result then transfers.
// Synchronous active-low reset clears state to idle, forward, zero duty.
// A stalled result holds; the input register then takes one more item
// before o_in_stall rises.
// ----------------------------------------------------------------------------
module motor_soft_start_sequencer_core #(
    parameter int unsigned DUTY_WIDTH  = mss_pkg::DUTY_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH = mss_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_kind,
    input  logic signed [16:0]              i_speed,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [DUTY_WIDTH-1:0]           o_duty,
    output logic                            o_reverse_dir,
    output logic                            o_busy_res,
    output logic                            o_running,
    output logic [15:0]                     o_speed_now,
    output logic                            o_rejected,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // sequence phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BRAKE  = 3'd1;
    localparam logic [2:0] PH_SETTLE = 3'd2;
    localparam logic [2:0] PH_HOLD   = 3'd3;
    localparam logic [2:0] PH_RAMP   = 3'd4;

    // reciprocal of ten: (x * 0xCCCD) >> 19 is exact for 16-bit x
    localparam logic [15:0] RECIP_TEN = 16'hCCCD;
    localparam int unsigned RECIP_SH  = 19;
    localparam int unsigned LVL_W     = 17;

    mss_pkg::t_cfg          cfg;
    logic [DUTY_WIDTH-1:0]  max_speed;

    // input register
    logic                   r_in_valid;
    logic [2:0]             r_in_kind;
    logic signed [16:0]     r_in_speed;
    logic                   advance;
    logic                   in_xfer;

    // sequencer state
    logic [DUTY_WIDTH-1:0]  r_duty,  n_duty;
    logic                   r_rev,   n_rev;
    logic [DUTY_WIDTH-1:0]  r_rec,   n_rec;
    logic [DUTY_WIDTH-1:0]  r_tgt,   n_tgt;
    logic [LVL_W-1:0]       r_ramp,  n_ramp;
    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_wc,    n_wc;
    logic                   r_pend,  n_pend;
    logic                   n_rejected;

    // result register
    logic                   r_out_valid;
    logic [DUTY_WIDTH-1:0]  r_o_duty;
    logic                   r_o_rev;
    logic                   r_o_busy;
    logic                   r_o_running;
    logic [15:0]            r_o_speed;
    logic                   r_o_rejected;

    // scratch for the next-state logic
    logic                   go_brake, go_settle, go_hold, go_ramp, go_finish;
    logic [15:0]            spd16;
    logic [15:0]            mx16;
    logic                   dir;
    logic [31:0]            prod;
    logic [LVL_W-1:0]       tenth;
    logic [LVL_W-1:0]       start;

    // wait length saturated to the counter width
    function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [15:0] ticks);
        logic [COUNT_WIDTH-1:0] cnt;
        if (COUNT_WIDTH >= 16) begin
            cnt = COUNT_WIDTH'(ticks);
        end else if ((ticks >> COUNT_WIDTH) != 16'd0) begin
            cnt = '1;
        end else begin
            cnt = COUNT_WIDTH'(ticks);
        end
        return cnt;
    endfunction

    mss_cfg_regs #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_max_speed (max_speed)
    );

    // handshake: the held item moves on unless the result is stuck
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_kind  <= i_kind;
            r_in_speed <= i_speed;
        end
    end

    // next state for the held item
    always_comb begin
        n_duty     = r_duty;
        n_rev      = r_rev;
        n_rec      = r_rec;
        n_tgt      = r_tgt;
        n_ramp     = r_ramp;
        n_phase    = r_phase;
        n_wc       = r_wc;
        n_pend     = r_pend;
        n_rejected = 1'b0;
        go_brake   = 1'b0;
        go_settle  = 1'b0;
        go_hold    = 1'b0;
        go_ramp    = 1'b0;
        go_finish  = 1'b0;
        mx16       = 16'(max_speed);
        spd16      = 16'd0;
        dir        = r_rev;
        prod       = 32'd0;
        tenth      = '0;
        start      = '0;

        // decode: ticks count down a wait, commands start a sequence
        if (r_in_kind == mss_pkg::KIND_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_wc != '0) begin
                    n_wc = r_wc - COUNT_WIDTH'(1);
                end
                if (n_wc == '0) begin
                    case (r_phase)
                        PH_BRAKE:  go_settle = 1'b1;
                        PH_SETTLE: go_hold   = 1'b1;
                        PH_HOLD:   go_ramp   = 1'b1;
                        PH_RAMP: begin
                            n_ramp  = r_ramp + LVL_W'(cfg.ramp_step);
                            go_ramp = 1'b1;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end else if (r_in_kind <= mss_pkg::KIND_REV_KEEP) begin
            if (r_phase != PH_IDLE) begin
                n_rejected = 1'b1;
            end else if (r_in_kind == mss_pkg::KIND_STOP) begin
                n_duty = '0;
                n_rec  = '0;
            end else begin
                if (r_in_kind >= mss_pkg::KIND_FWD_KEEP) begin
                    spd16 = 16'(r_rec);
                end else if (r_in_speed[16]) begin
                    spd16 = 16'd0;
                end else begin
                    spd16 = r_in_speed[15:0];
                end
                if (spd16 > mx16) begin
                    spd16 = mx16;
                end
                if (r_in_kind == mss_pkg::KIND_FWD ||
                    r_in_kind == mss_pkg::KIND_FWD_KEEP) begin
                    dir = 1'b0;
                end else if (r_in_kind == mss_pkg::KIND_REV ||
                             r_in_kind == mss_pkg::KIND_REV_KEEP) begin
                    dir = 1'b1;
                end
                n_tgt  = DUTY_WIDTH'(spd16);
                n_pend = dir;
                if (dir != r_rev && r_rec != '0) begin
                    go_brake = 1'b1;
                end else begin
                    go_settle = 1'b1;
                end
            end
        end

        // brake: zero duty and forget the speed
        if (go_brake) begin
            n_duty = '0;
            n_rec  = '0;
            if (cfg.brake_ticks == '0) begin
                go_settle = 1'b1;
            end else begin
                n_wc    = load_count(cfg.brake_ticks);
                n_phase = PH_BRAKE;
            end
        end

        // settle: drive the direction line
        if (go_settle) begin
            n_rev = n_pend;
            if (cfg.settle_ticks == '0) begin
                go_hold = 1'b1;
            end else begin
                n_wc    = load_count(cfg.settle_ticks);
                n_phase = PH_SETTLE;
            end
        end

        // hold: starting duty is max(floor, target / 10)
        if (go_hold) begin
            if (n_tgt == '0) begin
                go_finish = 1'b1;
            end else begin
                prod  = 16'(n_tgt) * RECIP_TEN;
                tenth = LVL_W'(prod >> RECIP_SH);
                start = (tenth < LVL_W'(cfg.start_floor)) ? LVL_W'(cfg.start_floor) : tenth;
                n_ramp = start;
                n_duty = DUTY_WIDTH'(start);
                if (cfg.hold_ticks == '0) begin
                    go_ramp = 1'b1;
                end else begin
                    n_wc    = load_count(cfg.hold_ticks);
                    n_phase = PH_HOLD;
                end
            end
        end

        // ramp: next level, or done once the target is reached
        if (go_ramp) begin
            if (n_ramp < LVL_W'(n_tgt) && cfg.step_ticks != '0) begin
                n_duty  = DUTY_WIDTH'(n_ramp);
                n_wc    = load_count(cfg.step_ticks);
                n_phase = PH_RAMP;
            end else begin
                go_finish = 1'b1;
            end
        end

        // finish: target becomes the recorded speed
        if (go_finish) begin
            n_duty  = n_tgt;
            n_rec   = n_tgt;
            n_phase = PH_IDLE;
            n_wc    = '0;
        end
    end

    // sequencer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= '0;
            r_rev   <= 1'b0;
            r_rec   <= '0;
            r_tgt   <= '0;
            r_ramp  <= '0;
            r_phase <= PH_IDLE;
            r_wc    <= '0;
            r_pend  <= 1'b0;
        end else if (advance) begin
            r_duty  <= n_duty;
            r_rev   <= n_rev;
            r_rec   <= n_rec;
            r_tgt   <= n_tgt;
            r_ramp  <= n_ramp;
            r_phase <= n_phase;
            r_wc    <= n_wc;
            r_pend  <= n_pend;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_duty     <= n_duty;
            r_o_rev      <= n_rev;
            r_o_busy     <= (n_phase != PH_IDLE);
            r_o_running  <= (n_rec != '0);
            r_o_speed    <= 16'(n_rec);
            r_o_rejected <= n_rejected;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_o_duty;
    assign o_reverse_dir = r_o_rev;
    assign o_busy_res    = r_o_busy;
    assign o_running     = r_o_running;
    assign o_speed_now   = r_o_speed;
    assign o_rejected    = r_o_rejected;

endmodule

[dv/motor_soft_start_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_soft_start_sequencer_core_tb: self-checking bench for the soft starter
// Drives ticks and drive commands through the valid/stall input channel,
// predicts duty, direction and status for every transfer, and compares each
// result transfer field by field. Covers reset settings, register masking,
// busy rejects, corner settings, back-pressure, long waits, and random
// traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module motor_soft_start_sequencer_core_tb;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_BRAKE, SEQ_SETTLE, SEQ_HOLD, SEQ_RAMP
    } t_seq;

    typedef struct packed {
        logic [15:0] duty;
        logic        reverse_dir;
        logic        busy;
        logic        running;
        logic [15:0] speed_now;
        logic        rejected;
    } t_drive_status;

    // DUT connections
    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [2:0]                      i_kind;
    logic signed [16:0]              i_speed;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [15:0]                     o_duty;
    logic                            o_reverse_dir;
    logic                            o_busy_res;
    logic                            o_running;
    logic [15:0]                     o_speed_now;
    logic                            o_rejected;
    logic                            i_cfg_we;
    logic [mss_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [mss_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // predicted register contents
    logic [mss_pkg::SBITS_W-1:0] cur_bits;
    logic [mss_pkg::TICKS_W-1:0] cur_brake, cur_settle, cur_hold, cur_step_ticks;
    logic [mss_pkg::BYTE_W-1:0]  cur_ramp_step, cur_floor;

    // predicted sequencer state
    logic [15:0] duty_pred, speed_pred, target_pred, wait_pred;
    logic [16:0] ramp_pred;
    logic        dir_pred, next_dir_pred;
    t_seq        seq_pred;

    t_drive_status status_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned rx_hold_req   = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned fail_count    = 0;
    int unsigned idle_cycles   = 0;

    motor_soft_start_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_speed       (i_speed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_duty        (o_duty),
        .o_reverse_dir (o_reverse_dir),
        .o_busy_res    (o_busy_res),
        .o_running     (o_running),
        .o_speed_now   (o_speed_now),
        .o_rejected    (o_rejected),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer prediction
    // ------------------------------------------------------------------
    function automatic int unsigned top_speed();
        int unsigned b;
        b = cur_bits;
        if (b < 1) b = 1;
        if (b > mss_pkg::DUTY_WIDTH_DEF) b = mss_pkg::DUTY_WIDTH_DEF;
        return (32'd1 << b) - 1;
    endfunction

    function automatic void seq_finish();
        duty_pred  = target_pred;
        speed_pred = target_pred;
        seq_pred   = SEQ_IDLE;
        wait_pred  = '0;
    endfunction

    function automatic void seq_enter_ramp();
        if (ramp_pred < {1'b0, target_pred} && cur_step_ticks != 0) begin
            duty_pred = ramp_pred[15:0];
            wait_pred = cur_step_ticks;
            seq_pred  = SEQ_RAMP;
        end else begin
            seq_finish();
        end
    endfunction

    function automatic void seq_enter_hold();
        logic [15:0] start;
        if (target_pred == 0) begin
            seq_finish();
            return;
        end
        start = 16'(target_pred / 16'd10);
        if (start < {8'd0, cur_floor}) start = {8'd0, cur_floor};
        ramp_pred = {1'b0, start};
        duty_pred = start;
        if (cur_hold == 0) begin
            seq_enter_ramp();
        end else begin
            wait_pred = cur_hold;
            seq_pred  = SEQ_HOLD;
        end
    endfunction

    function automatic void seq_enter_settle();
        dir_pred = next_dir_pred;
        if (cur_settle == 0) begin
            seq_enter_hold();
        end else begin
            wait_pred = cur_settle;
            seq_pred  = SEQ_SETTLE;
        end
    endfunction

    function automatic void seq_enter_brake();
        duty_pred  = '0;
        speed_pred = '0;
        if (cur_brake == 0) begin
            seq_enter_settle();
        end else begin
            wait_pred = cur_brake;
            seq_pred  = SEQ_BRAKE;
        end
    endfunction

    function automatic void seq_wait_over();
        case (seq_pred)
            SEQ_BRAKE:  seq_enter_settle();
            SEQ_SETTLE: seq_enter_hold();
            SEQ_HOLD:   seq_enter_ramp();
            SEQ_RAMP: begin
                ramp_pred = ramp_pred + ((cur_ramp_step == 0) ? 17'd1 : 17'(cur_ramp_step));
                seq_enter_ramp();
            end
            default:    seq_pred = SEQ_IDLE;
        endcase
    endfunction

    // advances the predicted state by one item and returns its status
    function automatic t_drive_status predict_drive_status(input mss_pkg::t_kind kind,
                                                           input logic [16:0] speed);
        t_drive_status st;
        logic          rej;
        logic [15:0]   spd;
        int unsigned   mx;
        rej = 1'b0;
        if (kind == mss_pkg::KIND_TICK) begin
            if (seq_pred != SEQ_IDLE) begin
                if (wait_pred > 0) wait_pred = wait_pred - 16'd1;
                if (wait_pred == 0) seq_wait_over();
            end
        end else if (kind != mss_pkg::KIND_UNUSED) begin
            if (seq_pred != SEQ_IDLE) begin
                rej = 1'b1;
            end else if (kind == mss_pkg::KIND_STOP) begin
                duty_pred  = '0;
                speed_pred = '0;
            end else begin
                mx = top_speed();
                if (kind == mss_pkg::KIND_FWD_KEEP || kind == mss_pkg::KIND_REV_KEEP)
                    spd = speed_pred;
                else if (speed[16]) spd = '0;
                else spd = speed[15:0];
                if (spd > mx) spd = 16'(mx);
                if (kind == mss_pkg::KIND_FWD || kind == mss_pkg::KIND_FWD_KEEP)
                    next_dir_pred = 1'b0;
                else if (kind == mss_pkg::KIND_REV || kind == mss_pkg::KIND_REV_KEEP)
                    next_dir_pred = 1'b1;
                else next_dir_pred = dir_pred;
                target_pred = spd;
                if (next_dir_pred != dir_pred && speed_pred > 0) seq_enter_brake();
                else seq_enter_settle();
            end
        end
        st.duty        = duty_pred;
        st.reverse_dir = dir_pred;
        st.busy        = (seq_pred != SEQ_IDLE);
        st.running     = (speed_pred > 0);
        st.speed_now   = speed_pred;
        st.rejected    = rej;
        return st;
    endfunction

    // spread of requested speeds: in range, near the clamp, negative, raw
    function automatic logic [16:0] pick_speed();
        int unsigned mx, r, hi, lo;
        mx = top_speed();
        r  = $urandom_range(99);
        hi = (mx + 4 > 65535) ? 65535 : mx + 4;
        lo = (mx > 3) ? mx - 3 : 0;
        if (r < 30)      return 17'($urandom_range(mx));
        else if (r < 45) return 17'($urandom_range(hi, lo));
        else if (r < 60) return {1'b1, 16'($urandom)};
        else if (r < 80) return 17'($urandom);
        else             return {1'b0, 16'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // one input transfer; valid stays high on return for back-to-back items
    task automatic send_item(input mss_pkg::t_kind kind, input logic [16:0] speed);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_speed    <= speed;
        do @(posedge i_clk); while (o_in_stall);
        status_q.push_back(predict_drive_status(kind, speed));
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // register writes only go in with the core drained
    task automatic cfg_write(input logic [mss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mss_pkg::CFG_DATA_W-1:0] data);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            mss_pkg::REG_SPEED_BITS:   cur_bits       = data[mss_pkg::SBITS_W-1:0];
            mss_pkg::REG_BRAKE_TICKS:  cur_brake      = data;
            mss_pkg::REG_SETTLE_TICKS: cur_settle     = data;
            mss_pkg::REG_HOLD_TICKS:   cur_hold       = data;
            mss_pkg::REG_STEP_TICKS:   cur_step_ticks = data;
            mss_pkg::REG_RAMP_STEP:    cur_ramp_step  = data[mss_pkg::BYTE_W-1:0];
            mss_pkg::REG_START_FLOOR:  cur_floor      = data[mss_pkg::BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_waits(input logic [15:0] brake, input logic [15:0] settle,
                             input logic [15:0] hold, input logic [15:0] step);
        cfg_write(mss_pkg::REG_BRAKE_TICKS, brake);
        cfg_write(mss_pkg::REG_SETTLE_TICKS, settle);
        cfg_write(mss_pkg::REG_HOLD_TICKS, hold);
        cfg_write(mss_pkg::REG_STEP_TICKS, step);
    endtask

    task automatic tick_until_idle();
        while (seq_pred != SEQ_IDLE) send_item(mss_pkg::KIND_TICK, 17'($urandom));
    endtask

    // short waits keep sequences completing; wide speeds get coarse steps
    task automatic randomize_config();
        logic [mss_pkg::SBITS_W-1:0] bits;
        int unsigned                 r, eff;
        r = $urandom_range(99);
        if (r < 70)      bits = mss_pkg::SBITS_W'($urandom_range(10, 1));
        else if (r < 85) bits = mss_pkg::SBITS_W'($urandom_range(16, 11));
        else if (r < 92) bits = '0;
        else             bits = mss_pkg::SBITS_W'($urandom_range(31, 17));
        eff = (bits == 0) ? 1 : (bits > 16) ? 16 : bits;
        cfg_write(mss_pkg::REG_SPEED_BITS, mss_pkg::CFG_DATA_W'(bits));
        set_waits(($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(6, 1)),
                  ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(6, 1)),
                  ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(6, 1)),
                  ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(4, 1)));
        if (eff > 10)
            cfg_write(mss_pkg::REG_RAMP_STEP, 16'($urandom_range(255, 128)));
        else if (eff > 6)
            cfg_write(mss_pkg::REG_RAMP_STEP, 16'($urandom_range(255, 24)));
        else
            cfg_write(mss_pkg::REG_RAMP_STEP, 16'($urandom_range(20)));
        cfg_write(mss_pkg::REG_START_FLOOR,
                  ($urandom_range(1) == 0) ? 16'($urandom_range(20))
                                           : 16'($urandom_range(255)));
    endtask

    // mostly ticks while a sequence runs, mostly commands while idle
    task automatic send_random_item(output bit counted);
        int unsigned    r;
        mss_pkg::t_kind k;
        bit             was_idle;
        r        = $urandom_range(99);
        was_idle = (seq_pred == SEQ_IDLE);
        if (!was_idle) begin
            if (r < 88) k = mss_pkg::KIND_TICK;
            else if (r < 97)
                k = mss_pkg::t_kind'($urandom_range(int'(mss_pkg::KIND_REV_KEEP),
                                                    int'(mss_pkg::KIND_FWD)));
            else k = mss_pkg::KIND_UNUSED;
        end else begin
            if (r < 62)
                k = mss_pkg::t_kind'($urandom_range(int'(mss_pkg::KIND_REV_KEEP),
                                                    int'(mss_pkg::KIND_FWD)));
            else if (r < 90) k = mss_pkg::KIND_TICK;
            else k = mss_pkg::KIND_UNUSED;
        end
        counted = (k != mss_pkg::KIND_UNUSED) && !(was_idle && k == mss_pkg::KIND_TICK);
        send_item(k, (k == mss_pkg::KIND_TICK) ? 17'($urandom) : pick_speed());
    endtask

    task automatic run_random_phase(input int unsigned n, input int unsigned s_pct,
                                    input int unsigned r_pct);
        int unsigned sent;
        bit          counted;
        randomize_config();
        send_idle_pct = s_pct;
        rx_stall_pct  = r_pct;
        sent = 0;
        while (sent < n) begin
            send_random_item(counted);
            if (counted) sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset register values drive one full soft start
    task automatic test_reset_defaults();
        send_item(mss_pkg::KIND_UNUSED, 17'h1FFFF);
        send_item(mss_pkg::KIND_TICK, 17'h00000);
        send_item(mss_pkg::KIND_STOP, 17'h0AAAA);
        send_item(mss_pkg::KIND_FWD, 17'd40);
        tick_until_idle();
    endtask

    // upper data bits are dropped; reversal brake and busy rejects
    task automatic test_register_masking();
        int k;
        cfg_write(mss_pkg::REG_SPEED_BITS, 16'hFFE4);
        set_waits(16'd2, 16'd1, 16'd1, 16'd1);
        cfg_write(mss_pkg::REG_RAMP_STEP, 16'hAB03);
        cfg_write(mss_pkg::REG_START_FLOOR, 16'h1202);
        send_item(mss_pkg::KIND_FWD, 17'd100);
        tick_until_idle();
        send_item(mss_pkg::KIND_REV, 17'd7);
        for (k = int'(mss_pkg::KIND_FWD); k <= int'(mss_pkg::KIND_REV_KEEP); k++)
            send_item(mss_pkg::t_kind'(k), 17'd3);
        send_item(mss_pkg::KIND_UNUSED, 17'd3);
        tick_until_idle();
        send_item(mss_pkg::KIND_FWD_KEEP, 17'h1FFFF);
        tick_until_idle();
        send_item(mss_pkg::KIND_REV_KEEP, 17'd0);
        tick_until_idle();
        send_item(mss_pkg::KIND_SPEED, 17'h1FFF0);
        tick_until_idle();
        send_item(mss_pkg::KIND_SPEED, 17'd9);
        tick_until_idle();
        send_item(mss_pkg::KIND_STOP, 17'd0);
    endtask

    // out-of-range speed bits, zero ramp step, floor over target, zero waits
    task automatic test_corner_settings();
        cfg_write(mss_pkg::REG_SPEED_BITS, 16'd0);
        send_item(mss_pkg::KIND_FWD, 17'h0FFFF);
        tick_until_idle();
        cfg_write(mss_pkg::REG_SPEED_BITS, 16'd31);
        cfg_write(mss_pkg::REG_RAMP_STEP, 16'd0);
        cfg_write(mss_pkg::REG_START_FLOOR, 16'd255);
        set_waits(16'd0, 16'd0, 16'd1, 16'd1);
        send_item(mss_pkg::KIND_FWD, 17'd200);
        tick_until_idle();
        send_item(mss_pkg::KIND_FWD, 17'd260);
        tick_until_idle();
        cfg_write(mss_pkg::REG_STEP_TICKS, 16'd0);
        send_item(mss_pkg::KIND_FWD, 17'h0FFFF);
        tick_until_idle();
        cfg_write(mss_pkg::REG_HOLD_TICKS, 16'd0);
        send_item(mss_pkg::KIND_REV, 17'd1000);
        cfg_write(mss_pkg::REG_RAMP_STEP, 16'd255);
        cfg_write(mss_pkg::REG_START_FLOOR, 16'd0);
        cfg_write(mss_pkg::REG_STEP_TICKS, 16'd3);
        cfg_write(mss_pkg::REG_SPEED_BITS, 16'd16);
        send_item(mss_pkg::KIND_FWD, 17'h10000);
        tick_until_idle();
        send_item(mss_pkg::KIND_SPEED, 17'd2000);
        tick_until_idle();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int  i;
        bit  counted;
        randomize_config();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        @(posedge i_clk);
        rx_hold_req = 300;
        for (i = 0; i < 60; i++) send_random_item(counted);
        wait_results_done();
    endtask

    // long brake, settle, hold and step waits through one reversal
    task automatic test_long_waits();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        set_waits(16'd0, 16'd0, 16'd0, 16'd0);
        cfg_write(mss_pkg::REG_SPEED_BITS, 16'd16);
        cfg_write(mss_pkg::REG_START_FLOOR, 16'd0);
        cfg_write(mss_pkg::REG_RAMP_STEP, 16'd255);
        send_item(mss_pkg::KIND_FWD, 17'd5);
        set_waits(16'd240, 16'd120, 16'd120, 16'd60);
        send_item(mss_pkg::KIND_REV, 17'd5);
        tick_until_idle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(200, 0, 0);
        run_random_phase(200, 58, 0);
        run_random_phase(200, 0, 58);
        run_random_phase(200, 36, 36);
        run_random_phase(100, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // result side: stall generation and checking
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_drive_status want, got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_duty, o_reverse_dir, o_busy_res, o_running, o_speed_now, o_rejected};
            if (status_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
                want = status_q.pop_front();
                if (got.duty != want.duty || got.reverse_dir != want.reverse_dir ||
                    got.busy != want.busy || got.running != want.running ||
                    got.speed_now != want.speed_now || got.rejected != want.rejected) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: mismatch exp duty=%0d rev=%0b busy=%0b run=%0b ",
                                  "spd=%0d rej=%0b | got duty=%0d rev=%0b busy=%0b run=%0b ",
                                  "spd=%0d rej=%0b"}, $realtime,
                                 want.duty, want.reverse_dir, want.busy, want.running,
                                 want.speed_now, want.rejected,
                                 got.duty, got.reverse_dir, got.busy, got.running,
                                 got.speed_now, got.rejected);
                end
            end
        end
    end

    // no transfer on either channel for too long ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = mss_pkg::KIND_TICK;
        i_speed     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = mss_pkg::REG_SPEED_BITS;
        i_cfg_data  = '0;

        cur_bits       = mss_pkg::RST_SPEED_BITS;
        cur_brake      = mss_pkg::RST_BRAKE_TICKS;
        cur_settle     = mss_pkg::RST_SETTLE_TICKS;
        cur_hold       = mss_pkg::RST_HOLD_TICKS;
        cur_step_ticks = mss_pkg::RST_STEP_TICKS;
        cur_ramp_step  = mss_pkg::RST_RAMP_STEP;
        cur_floor      = mss_pkg::RST_START_FLOOR;
        duty_pred      = '0;
        speed_pred     = '0;
        target_pred    = '0;
        wait_pred      = '0;
        ramp_pred      = '0;
        dir_pred       = 1'b0;
        next_dir_pred  = 1'b0;
        seq_pred       = SEQ_IDLE;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_masking();
        test_corner_settings();
        test_backpressure();
        test_long_waits();
        test_random_traffic();

        wait_results_done();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && status_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
